// ===== rtl/pag_pkg.sv =====
// Shared types, constants and register codes for the pixel gain/offset pipeline.
`timescale 1ns / 1ps

package pag_pkg;

    // Pixel range on the input side; values at or above it saturate.
    localparam int PIXEL_LEVELS = 256;
    localparam int PIX_W        = 8;
    localparam logic [PIX_W-1:0] PIXEL_MAX = PIX_W'(PIXEL_LEVELS - 1);

    // Output clip bound is always 0..255.
    localparam logic [7:0] CLIP_MAX = 8'hFF;

    // APB register file.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Datapath widths.
    localparam int Q_W       = 24;            // floor(a * 2^16 / b)
    localparam int V_W       = 26;            // signed integer op result
    localparam int ACC_W     = V_W + DATA_W;  // product and accumulator
    localparam int FRAC_INT  = 16;
    localparam int FRAC_DIV  = 32;
    localparam int DIV_STEPS = 8;             // quotient bits per divider stage

    // Divide by zero behaves as divide by 0.00001.
    localparam int ZERO_DIV_FACTOR = 100000;

    localparam logic signed [ACC_W-1:0] TOP_INT = ACC_W'(64'sd255 <<< FRAC_INT);
    localparam logic signed [ACC_W-1:0] TOP_DIV = ACC_W'(64'sd255 <<< FRAC_DIV);

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_ABSDIFF = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_PASS    = 3'd5
    } pag_op_t;

    typedef enum logic [1:0] {
        REG_GAIN      = 2'd0,
        REG_OFFSET    = 2'd1,
        REG_OPERATION = 2'd2
    } pag_reg_t;

    localparam logic [DATA_W-1:0] GAIN_RESET   = 32'h0001_0000;
    localparam logic [DATA_W-1:0] OFFSET_RESET = 32'h0000_0000;

    // Payload carried through the divider stages.
    typedef struct packed {
        logic [PIX_W-1:0]        b;
        logic [PIX_W-1:0]        rem;
        logic [Q_W-1:0]          q;
        logic signed [V_W-1:0]   v;
        logic                    use_q;
    } pag_div_t;

    // Accumulated value ready for clipping.
    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic                    use_q;
    } pag_acc_t;

    // Per-stage control of the multiply/add unit.
    typedef struct packed {
        logic mul;
        logic add;
    } pag_mac_ctl_t;

endpackage

// ===== rtl/pag_div_stage.sv =====
// One registered stage of the restoring divider: eight quotient bits per stage.
`timescale 1ns / 1ps

module pag_div_stage
    import pag_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [DIV_STEPS-1:0] num,
    input  pag_div_t             din,
    output logic                 valid,
    output pag_div_t             dout
);

    logic     valid_reg;
    pag_div_t data_reg;
    pag_div_t data_next;

    always_comb
    begin
        logic [PIX_W-1:0] rem;
        logic [PIX_W:0]   trial;
        logic [Q_W-1:0]   q;
        rem       = din.rem;
        q         = din.q;
        data_next = din;
        // Shift in dividend bits msb first; subtract when the divisor fits.
        for (int i = DIV_STEPS - 1; i >= 0; i--)
        begin
            trial = {rem, num[i]};
            if (trial >= {1'b0, din.b})
            begin
                trial = trial - {1'b0, din.b};
                q     = {q[Q_W-2:0], 1'b1};
            end
            else
            begin
                q = {q[Q_W-2:0], 1'b0};
            end
            rem = trial[PIX_W-1:0];
        end
        data_next.rem = rem;
        data_next.q   = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign dout  = data_reg;

endmodule

// ===== rtl/pag_mac.sv =====
// Gain multiply stage followed by the offset add stage.
`timescale 1ns / 1ps

module pag_mac
    import pag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pag_mac_ctl_t      en,
    input  logic              valid_in,
    input  pag_div_t          din,
    input  logic [DATA_W-1:0] gain,
    input  logic [DATA_W-1:0] offset,
    output pag_mac_ctl_t      valid,
    output pag_acc_t          dout
);

    pag_mac_ctl_t            valid_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic                    use_q_reg;
    pag_acc_t                acc_reg;
    pag_acc_t                acc_next;

    // Quotient (Q8.16) or integer result times Q16.16 gain.
    always_comb
    begin
        logic signed [V_W-1:0]    m;
        logic signed [DATA_W-1:0] g;
        g = $signed(gain);
        if (din.use_q)
        begin
            m = $signed({{(V_W-Q_W){1'b0}}, din.q});
        end
        else
        begin
            m = din.v;
        end
        prod_next = m * g;
    end

    // Offset lines up at 16 fraction bits, or at 32 on the quotient path.
    always_comb
    begin
        logic signed [ACC_W-1:0] off_int;
        logic signed [ACC_W-1:0] off_div;
        off_int = ACC_W'($signed(offset));
        off_div = ACC_W'($signed({offset, {FRAC_INT{1'b0}}}));
        acc_next.use_q = use_q_reg;
        acc_next.acc   = prod_reg + (use_q_reg ? off_div : off_int);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en.mul)
            begin
                valid_reg.mul <= valid_in;
            end
            if (en.add)
            begin
                valid_reg.add <= valid_reg.mul;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg  <= prod_next;
            use_q_reg <= din.use_q;
        end
        if (en.add)
        begin
            acc_reg <= acc_next;
        end
    end

    assign valid = valid_reg;
    assign dout  = acc_reg;

endmodule

// ===== rtl/pag_clip.sv =====
// Output stage: clip the accumulator to 0..255, truncate, hold the result beat.
`timescale 1ns / 1ps

module pag_clip
    import pag_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       valid_in,
    input  pag_acc_t   din,
    output logic       valid,
    output logic [7:0] pix
);

    logic       valid_reg;
    logic [7:0] pix_reg;
    logic [7:0] pix_next;

    always_comb
    begin
        logic at_top;
        at_top = din.use_q ? (din.acc >= TOP_DIV) : (din.acc >= TOP_INT);
        if (din.acc <= 0)
        begin
            pix_next = 8'd0;
        end
        else if (at_top)
        begin
            pix_next = CLIP_MAX;
        end
        else if (din.use_q)
        begin
            pix_next = din.acc[FRAC_DIV +: 8];
        end
        else
        begin
            pix_next = din.acc[FRAC_INT +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= pix_next;
        end
    end

    assign valid = valid_reg;
    assign pix   = pix_reg;

endmodule

// ===== rtl/pixel_arithmetic_gain_offset.sv =====
// Top level: saturating pixel arithmetic with signed Q16.16 gain and offset.
//
//   channel   dir   signals                         beat contents
//   -------   ---   -----------------------------   -----------------------------
//   s_axis    in    tvalid tready tdata[15:0]       pixel_a [7:0], pixel_b [15:8]
//   m_axis    out   tvalid tready tdata[7:0]        result_pixel [7:0]
//   apb       in    psel penable pwrite paddr[3:0]  gain 0x0, offset 0x4,
//                   pwdata prdata pready            operation 0x8
//
// One beat per clock sustained while m_axis_tready stays high; the pipeline is
// three divider stages (eight quotient bits each), the gain multiply, the offset
// add and the clip/output register.
// rst_n clears all valid bits and loads gain = 1.0, offset = 0, operation = pass.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stall at m_axis holds each full stage with no empty stage after it.
`timescale 1ns / 1ps

module pixel_arithmetic_gain_offset
    import pag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [7:0] pixel_a, [15:8] pixel_b

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata    // [7:0] result_pixel
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] gain_reg;
    logic [DATA_W-1:0] offset_reg;
    logic [2:0]        operation_reg;

    assign pready = 1'b1;

    // Take a write in the access phase; decode the word index only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            offset_reg    <= OFFSET_RESET;
            operation_reg <= OP_PASS;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_GAIN:      gain_reg      <= pwdata;
                REG_OFFSET:    offset_reg    <= pwdata;
                REG_OPERATION: operation_reg <= pwdata[2:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_GAIN:      prdata = gain_reg;
            REG_OFFSET:    prdata = offset_reg;
            REG_OPERATION: prdata = {{(DATA_W-3){1'b0}}, operation_reg};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance chain, output side first
    // ------------------------------------------------------------------
    logic         v_div0, v_div1, v_div2, v_out;
    logic         en_div0, en_div1, en_div2, en_out;
    pag_mac_ctl_t v_mac;
    pag_mac_ctl_t en_mac;

    assign en_out     = !v_out || m_axis_tready;
    assign en_mac.add = !v_mac.add || en_out;
    assign en_mac.mul = !v_mac.mul || en_mac.add;
    assign en_div2    = !v_div2 || en_mac.mul;
    assign en_div1    = !v_div1 || en_div2;
    assign en_div0    = !v_div0 || en_div1;

    assign s_axis_tready = en_div0;

    // ------------------------------------------------------------------
    // Input conditioning and the integer operation
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] pix_a;
    logic [PIX_W-1:0] pix_b;
    pag_div_t         div_in;

    // Saturate pixels at or above the level count.
    assign pix_a = (s_axis_tdata[7:0]  > PIXEL_MAX) ? PIXEL_MAX : s_axis_tdata[7:0];
    assign pix_b = (s_axis_tdata[15:8] > PIXEL_MAX) ? PIXEL_MAX : s_axis_tdata[15:8];

    always_comb
    begin
        logic signed [V_W-1:0] a_ext;
        logic signed [V_W-1:0] b_ext;
        a_ext = $signed({{(V_W-PIX_W){1'b0}}, pix_a});
        b_ext = $signed({{(V_W-PIX_W){1'b0}}, pix_b});

        div_in.b     = pix_b;
        div_in.rem   = '0;
        div_in.q     = '0;
        div_in.use_q = 1'b0;

        case (operation_reg)
            OP_ADD:     div_in.v = a_ext + b_ext;
            OP_SUB:     div_in.v = a_ext - b_ext;
            OP_ABSDIFF: div_in.v = (pix_a >= pix_b) ? (a_ext - b_ext) : (b_ext - a_ext);
            OP_MUL:     div_in.v = $signed(V_W'(16'(pix_a) * 16'(pix_b)));
            OP_DIV:
            begin
                // Zero divisor acts as 0.00001: scale a by 100000 exactly.
                div_in.v     = $signed(V_W'(32'(pix_a) * ZERO_DIV_FACTOR));
                div_in.use_q = (pix_b != '0);
            end
            default:    div_in.v = a_ext;
        endcase
    end

    // ------------------------------------------------------------------
    // Divider: a * 2^16 / b, dividend bits enter msb first
    // ------------------------------------------------------------------
    pag_div_t div0_out, div1_out, div2_out;

    pag_div_stage u_div0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_div0),
        .valid_in (s_axis_tvalid),
        .num      (pix_a),
        .din      (div_in),
        .valid    (v_div0),
        .dout     (div0_out)
    );

    // Low sixteen dividend bits are zero.
    pag_div_stage u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_div1),
        .valid_in (v_div0),
        .num      ('0),
        .din      (div0_out),
        .valid    (v_div1),
        .dout     (div1_out)
    );

    pag_div_stage u_div2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_div2),
        .valid_in (v_div1),
        .num      ('0),
        .din      (div1_out),
        .valid    (v_div2),
        .dout     (div2_out)
    );

    // ------------------------------------------------------------------
    // Gain, offset and clip
    // ------------------------------------------------------------------
    pag_acc_t mac_out;

    pag_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_mac),
        .valid_in (v_div2),
        .din      (div2_out),
        .gain     (gain_reg),
        .offset   (offset_reg),
        .valid    (v_mac),
        .dout     (mac_out)
    );

    pag_clip u_clip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_out),
        .valid_in (v_mac.add),
        .din      (mac_out),
        .valid    (v_out),
        .pix      (m_axis_tdata)
    );

    assign m_axis_tvalid = v_out;

endmodule

// ===== verif/pag_pixel_checker.sv =====
// Pixel gain/offset checker: tracks register writes, predicts each result pixel and compares.
`timescale 1ns / 1ps

module pag_pixel_checker
    import pag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,

    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [7:0] pixel_a, [15:8] pixel_b

    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [7:0]        m_axis_tdata,   // [7:0] result_pixel

    output int                mismatches,
    output int                pending_results
);

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [2:0] op;
        logic [7:0] pixel;
    } pixel_expect_t;

    // Shadow copy of the register file.
    longint        gain_q;
    longint        offset_q;
    logic [2:0]    op_code;

    pixel_expect_t expected_pixels[$];
    pixel_expect_t oldest;

    // Clip a value with frac fraction bits to 0..255, truncating toward zero.
    function automatic logic [7:0] clip_to_pixel(longint val, int frac);
        longint top;
        top = longint'(255) <<< frac;
        if (val <= 0)
            return 8'd0;
        if (val >= top)
            return CLIP_MAX;
        return 8'(val >>> frac);
    endfunction

    function automatic logic [7:0] predict_pixel(logic [7:0] a_in, logic [7:0] b_in);
        longint a;
        longint b;
        longint v;
        longint q;
        a = (a_in > PIXEL_MAX) ? longint'(PIXEL_MAX) : longint'(a_in);
        b = (b_in > PIXEL_MAX) ? longint'(PIXEL_MAX) : longint'(b_in);
        case (op_code)
            OP_ADD:     v = a + b;
            OP_SUB:     v = a - b;
            OP_ABSDIFF: v = (a >= b) ? (a - b) : (b - a);
            OP_MUL:     v = a * b;
            OP_DIV:
            begin
                // A zero divisor stands for 0.00001: quotient is a * 100000, integer path.
                if (b == 0)
                    v = a * ZERO_DIV_FACTOR;
                else
                begin
                    q = (a <<< FRAC_INT) / b;
                    return clip_to_pixel(q * gain_q + (offset_q <<< FRAC_INT), FRAC_DIV);
                end
            end
            default:    v = a;
        endcase
        return clip_to_pixel(v * gain_q + offset_q, FRAC_INT);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_q          <= longint'(signed'(GAIN_RESET));
            offset_q        <= longint'(signed'(OFFSET_RESET));
            op_code         <= OP_PASS;
            mismatches      <= 0;
            pending_results <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_GAIN:      gain_q   <= longint'(signed'(pwdata));
                    REG_OFFSET:    offset_q <= longint'(signed'(pwdata));
                    REG_OPERATION: op_code  <= pwdata[2:0];
                    default:       ;
                endcase
            end

            // Retire the oldest expectation before queuing a new one.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected result beat %0d, nothing pending",
                                 $time, m_axis_tdata);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    if (oldest.pixel !== m_axis_tdata)
                    begin
                        if (mismatches < 10)
                            $display("[%0t] result_pixel mismatch: op %0d a %0d b %0d exp %0d got %0d",
                                     $time, oldest.op, oldest.a, oldest.b, oldest.pixel,
                                     m_axis_tdata);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back({s_axis_tdata[7:0], s_axis_tdata[15:8], op_code,
                                           predict_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8])});

            pending_results <= expected_pixels.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for pixel_arithmetic_gain_offset: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb
    import pag_pkg::*;
();

    localparam int RANDOM_PHASES   = 16;
    localparam int BEATS_PER_PHASE = 50;     // 16 x 50 = 800 random beats
    localparam int WATCHDOG_LIMIT  = 4000;   // cycles with no beat on either stream
    localparam int DRAIN_CYCLES    = 12;     // six-stage pipe, doubled

    logic              clk = 1'b0;
    logic              rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;   // [7:0] pixel_a, [15:8] pixel_b

    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;   // [7:0] result_pixel

    int                mismatches;
    int                pending_results;
    int                idle_cycles = 0;
    bit                steady_input;   // phase runs the sender back to back

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pixel_arithmetic_gain_offset i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pag_pixel_checker i_pixel_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Gain mix: extremes, moderate factors within +/-4.0, small factors that keep
    // a multiply in range, and the full 32-bit space.
    function automatic logic [31:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_0000;
                default: return GAIN_RESET;
            endcase
        end
        if (r < 45)
            return 32'(int'($urandom_range(0, 524288)) - 262144);
        if (r < 85)
            return 32'($urandom_range(0, 2048));
        return $urandom();
    endfunction

    // Offset mix: extremes, values within +/-300.0, and the full 32-bit space.
    function automatic logic [31:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 2))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                default: return OFFSET_RESET;
            endcase
        end
        if (r < 80)
            return 32'(int'($urandom_range(0, 2 * 300 * 65536)) - 300 * 65536);
        return $urandom();
    endfunction

    // Pixel mix: lean on zero, full scale and tiny divisors.
    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'd0;
        if (r < 20)
            return PIXEL_MAX;
        if (r < 30)
            return 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // APB write: setup cycle, then access cycle; the write lands when pready is seen.
    task automatic reg_write(pag_reg_t idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic wait_drained();
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Registers change only with the pipe empty.
    task automatic configure(logic [DATA_W-1:0] gain, logic [DATA_W-1:0] offset,
                             logic [2:0] op);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        reg_write(REG_GAIN, gain);
        reg_write(REG_OFFSET, offset);
        reg_write(REG_OPERATION, 32'(op));
    endtask

    // Present one pixel pair and hold it until the beat is taken.
    task automatic send_pair(logic [7:0] pixel_a, logic [7:0] pixel_b);
        int gap;
        gap = steady_input ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pixel_b, pixel_a};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Result side: ready runs of random length, broken by random stalls.
    // One run in ten is a long stretch with no stall at all.
    initial
    begin
        int run;
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 30);
            @(negedge clk);
            m_axis_tready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    // Watchdog: end the run if neither stream moves a beat for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("** pixel_arithmetic_gain_offset: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] op;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        steady_input  = 1'b0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings (gain 1.0, offset 0, pass a).
        send_pair(PIXEL_MAX, 8'd0);
        send_pair(8'd0, PIXEL_MAX);

        // Directed: every operation code, the two spare codes included, at unit gain.
        for (int code = 0; code < 8; code++)
        begin
            configure(GAIN_RESET, OFFSET_RESET, 3'(code));
            send_pair(PIXEL_MAX, PIXEL_MAX);
            send_pair(PIXEL_MAX, 8'd0);
            send_pair(8'd0, PIXEL_MAX);
        end

        // Directed: divide by zero with negative and zero gain, offset 128.0.
        // Zero over zero gives the clipped offset; nonzero over zero follows the gain sign.
        configure(32'hFFFF_0000, 32'h0080_0000, OP_DIV);
        send_pair(8'd0, 8'd0);
        send_pair(8'd5, 8'd0);
        configure(32'h0000_0000, 32'h0080_0000, OP_DIV);
        send_pair(8'd5, 8'd0);

        // Random phases. The first two pin the register extremes; the first
        // eight walk every operation code, the rest pick codes at random.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            op = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            if (phase == 0)
                configure(32'h8000_0000, 32'h7FFF_FFFF, op);
            else if (phase == 1)
                configure(32'h7FFF_FFFF, 32'h8000_0000, op);
            else
                configure(pick_gain(), pick_offset(), op);
            steady_input = ($urandom_range(0, 3) == 0);
            repeat (BEATS_PER_PHASE)
                send_pair(pick_pixel(), pick_pixel());
        end

        // Drop valid, drain the pipe, then give stray beats a chance to show.
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results == 0)
            $display("** pixel_arithmetic_gain_offset: PASSED **");
        else
            $display("** pixel_arithmetic_gain_offset: FAILED **");
        $finish;
    end

endmodule
